/* rtl/idt_pkg.sv */
// shared types and constants for the interrupt delivery block
// no dependencies; used by idt_gate_store and idt_interrupt_delivery_top
`timescale 1ns / 1ps
`default_nettype none

package idt_pkg;

  typedef enum logic [1:0] {
    ACT_WRITE   = 2'd0,
    ACT_RAISE   = 2'd1,
    ACT_DELIVER = 2'd2,
    ACT_TRACE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_STACK   = 2'd0,
    KIND_DELIVER = 2'd1,
    KIND_FAULT   = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    FAULT_NONE    = 2'd0,
    FAULT_LIMIT   = 2'd1,
    FAULT_RAM     = 2'd2,
    FAULT_ABSENT  = 2'd3
  } fault_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_GATE,
    S_PUSH,
    S_FINAL
  } state_t;

  localparam logic [1:0] CFG_IDT_BASE  = 2'd0;
  localparam logic [1:0] CFG_IDT_LIMIT = 2'd1;
  localparam logic [1:0] CFG_RAM_LIMIT = 2'd2;

  localparam logic [7:0]  VEC_BASE      = 8'h20;
  localparam int          PRESENT_BIT   = 7;
  localparam logic [3:0]  GATE_TYPE_INT = 4'hE;
  localparam logic [31:0] FLAG_IF       = 32'h0000_0200;
  localparam logic [31:0] FLAG_FIXED    = 32'h0000_0002;
  localparam logic [31:0] RAM_LIMIT_RST = 32'h0400_0000;

  // descriptor store access between the sequencer and the store
  typedef struct packed {
    logic        en;
    logic [7:0]  idx;
    logic [63:0] data;
  } gate_wr_t;

  typedef struct packed {
    logic       en;
    logic [7:0] idx;
  } gate_rd_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] mem_addr;
    logic [31:0] mem_data;
    logic [31:0] handler_addr;
    logic [31:0] new_stack_ptr;
    logic        if_out;
    fault_t      fault_code;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

/* rtl/idt_gate_store.sv */
// gate descriptor store: synchronous memory with per-entry valid bits
// depends on idt_pkg for the access structs
`timescale 1ns / 1ps
`default_nettype none

module idt_gate_store #(
  parameter int GATE_ENTRIES = 256
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire idt_pkg::gate_wr_t wr,
  input  wire idt_pkg::gate_rd_t rd,
  output logic [63:0]           rd_data
);

  localparam int IDX_W = (GATE_ENTRIES > 1) ? $clog2(GATE_ENTRIES) : 1;

  logic [63:0]             mem [GATE_ENTRIES];
  logic [GATE_ENTRIES-1:0] valid;
  logic [63:0]             rdata;
  logic                    hit;
  logic                    wr_in_range;
  logic                    rd_in_range;

  assign wr_in_range = {1'b0, wr.idx} < 9'(GATE_ENTRIES);
  assign rd_in_range = {1'b0, rd.idx} < 9'(GATE_ENTRIES);

  always_ff @(posedge clk) begin
    if (wr.en && wr_in_range) begin
      mem[wr.idx[IDX_W-1:0]] <= wr.data;
    end
    if (rd.en) begin
      rdata <= mem[rd.idx[IDX_W-1:0]];
    end
  end

  // entries never written read as zero, i.e. not present
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      hit   <= 1'b0;
    end else begin
      if (wr.en && wr_in_range) begin
        valid[wr.idx[IDX_W-1:0]] <= 1'b1;
      end
      if (rd.en) begin
        hit <= rd_in_range && valid[rd.idx[IDX_W-1:0]];
      end
    end
  end

  assign rd_data = hit ? rdata : 64'd0;

endmodule

`default_nettype wire

/* rtl/idt_interrupt_delivery_top.sv */
// interrupt delivery top: config registers, pending mask and delivery sequencer
// depends on idt_pkg and idt_gate_store
// write and raise items answer in the cycle after acceptance, busy stays low
// delivery: a fault or "nothing delivered" shows after the check state (limit/ram
//   checks) or after the gate state (not present, after the descriptor read); a full
//   delivery shows 3 or 4 stack write slots then the delivered result, busy from check to final
// no new item is taken while busy; the push state issues one stack push per cycle
// reset puts config to reset values, clears pending mask and gate valid bits
`timescale 1ns / 1ps
`default_nettype none

module idt_interrupt_delivery_top #(
  parameter int GATE_ENTRIES = 256,
  parameter int IRQ_COUNT    = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // command channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  action,
  input  wire logic [7:0]  vector,
  input  wire logic [31:0] return_addr,
  input  wire logic        with_error,
  input  wire logic [31:0] error_word,
  input  wire logic [31:0] stack_ptr,
  input  wire logic [31:0] flags_in,
  input  wire logic        if_in,
  input  wire logic [7:0]  desc_index,
  input  wire logic [63:0] desc_data,
  input  wire logic [15:0] irq_lines,
  // configuration channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  // result channel, the receiver cannot stall it
  output logic             result_valid,
  output logic [1:0]       kind,
  output logic [31:0]      mem_addr,
  output logic [31:0]      mem_data,
  output logic [31:0]      handler_addr,
  output logic [31:0]      new_stack_ptr,
  output logic             if_out,
  output logic [1:0]       fault_code,
  output logic             last
);

  // configuration registers
  logic [31:0] idt_base;
  logic [15:0] idt_limit;
  logic [31:0] ram_limit;

  // sequencer state
  idt_pkg::state_t state, state_next;
  logic [IRQ_COUNT-1:0] pending, pending_next;

  // latched transaction fields
  idt_pkg::action_t act;
  logic [7:0]       vec_in;
  logic [31:0]      ret;
  logic             err_on;
  logic [31:0]      err_word;
  logic [31:0]      sp_in;
  logic [31:0]      flags;
  logic             if_v;

  // delivery working registers
  logic [31:0] sp_work, sp_work_next;
  logic [1:0]  step, step_next;
  logic [31:0] handler, handler_next;
  logic [15:0] sel, sel_next;
  logic        gate_int, gate_int_next;

  // result register
  idt_pkg::result_t res, res_next;
  logic             res_valid_next;

  // store access
  idt_pkg::gate_wr_t gate_wr;
  idt_pkg::gate_rd_t gate_rd;
  logic [63:0]       gate;

  logic        accept;
  logic [3:0]  line;
  logic [7:0]  vec_chk;
  logic [11:0] off_top;
  logic [32:0] ram_end;
  logic        lim_fault;
  logic        ram_fault;
  logic [31:0] sp_dec;
  logic [31:0] push_word;
  logic [31:0] saved_flags;
  logic [7:0]  gate_attr;
  logic [1:0]  last_step;

  assign accept    = start && !busy;
  assign busy      = (state != idt_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  idt_gate_store #(
    .GATE_ENTRIES(GATE_ENTRIES)
  ) u_store (
    .clk    (clk),
    .rst    (rst),
    .wr     (gate_wr),
    .rd     (gate_rd),
    .rd_data(gate)
  );

  // configuration writes, indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      idt_base  <= '0;
      idt_limit <= '0;
      ram_limit <= idt_pkg::RAM_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        idt_pkg::CFG_IDT_BASE:  idt_base  <= cfg_data;
        idt_pkg::CFG_IDT_LIMIT: idt_limit <= cfg_data[15:0];
        idt_pkg::CFG_RAM_LIMIT: ram_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // lowest pending line
  always_comb begin
    line = '0;
    for (int i = IRQ_COUNT - 1; i >= 0; i--) begin
      if (pending[i]) begin
        line = 4'(i);
      end
    end
  end

  // vector and table checks for the check cycle
  assign vec_chk   = (act == idt_pkg::ACT_TRACE) ? idt_pkg::VEC_BASE + {4'd0, line} : vec_in;
  assign off_top   = {1'b0, vec_chk, 3'b000} + 12'd7;
  assign lim_fault = {5'd0, off_top} > {1'b0, idt_limit};
  assign ram_end   = {1'b0, idt_base} + {22'd0, vec_chk, 3'b000} + 33'd8;
  assign ram_fault = ram_end > {1'b0, ram_limit};

  // frame words
  assign saved_flags = (flags & ~idt_pkg::FLAG_IF) | (if_v ? idt_pkg::FLAG_IF : 32'd0)
                       | idt_pkg::FLAG_FIXED;
  assign sp_dec      = sp_work - 32'd4;
  assign gate_attr   = gate[47:40];
  assign last_step   = err_on ? 2'd3 : 2'd2;

  always_comb begin
    case (step)
      2'd0:    push_word = saved_flags;
      2'd1:    push_word = {16'd0, sel};
      2'd2:    push_word = ret;
      default: push_word = err_word;
    endcase
  end

  // next state, store access and result
  always_comb begin
    state_next     = state;
    pending_next   = pending;
    sp_work_next   = sp_work;
    step_next      = step;
    handler_next   = handler;
    sel_next       = sel;
    gate_int_next  = gate_int;
    res_next       = res;
    res_valid_next = 1'b0;
    gate_wr.en     = 1'b0;
    gate_wr.idx    = desc_index;
    gate_wr.data   = desc_data;
    gate_rd.en     = 1'b0;
    gate_rd.idx    = vec_chk;

    case (state)
      idt_pkg::S_IDLE: begin
        if (accept) begin
          // ack for write and raise, taken straight from the ports
          res_next.kind          = idt_pkg::KIND_NONE;
          res_next.mem_addr      = '0;
          res_next.mem_data      = '0;
          res_next.handler_addr  = '0;
          res_next.new_stack_ptr = stack_ptr;
          res_next.if_out        = if_in;
          res_next.fault_code    = idt_pkg::FAULT_NONE;
          res_next.last          = 1'b1;
          case (idt_pkg::action_t'(action))
            idt_pkg::ACT_WRITE: begin
              gate_wr.en     = 1'b1;
              res_valid_next = 1'b1;
            end
            idt_pkg::ACT_RAISE: begin
              pending_next   = pending | irq_lines[IRQ_COUNT-1:0];
              res_valid_next = 1'b1;
            end
            default: begin
              state_next = idt_pkg::S_CHECK;
            end
          endcase
        end
      end

      idt_pkg::S_CHECK: begin
        res_next.kind          = idt_pkg::KIND_FAULT;
        res_next.mem_addr      = '0;
        res_next.mem_data      = '0;
        res_next.handler_addr  = '0;
        res_next.new_stack_ptr = sp_in;
        res_next.if_out        = if_v;
        res_next.fault_code    = idt_pkg::FAULT_NONE;
        res_next.last          = 1'b1;
        if (act == idt_pkg::ACT_TRACE && (pending == '0 || !if_v)) begin
          res_next.kind  = idt_pkg::KIND_NONE;
          res_valid_next = 1'b1;
          state_next     = idt_pkg::S_IDLE;
        end else begin
          // the serviced line stays cleared even if the delivery faults
          if (act == idt_pkg::ACT_TRACE) begin
            pending_next[line] = 1'b0;
          end
          if (lim_fault) begin
            res_next.fault_code = idt_pkg::FAULT_LIMIT;
            res_valid_next      = 1'b1;
            state_next          = idt_pkg::S_IDLE;
          end else if (ram_fault) begin
            res_next.fault_code = idt_pkg::FAULT_RAM;
            res_valid_next      = 1'b1;
            state_next          = idt_pkg::S_IDLE;
          end else begin
            gate_rd.en = 1'b1;
            state_next = idt_pkg::S_GATE;
          end
        end
      end

      idt_pkg::S_GATE: begin
        if (!gate_attr[idt_pkg::PRESENT_BIT]) begin
          res_next.kind          = idt_pkg::KIND_FAULT;
          res_next.mem_addr      = '0;
          res_next.mem_data      = '0;
          res_next.handler_addr  = '0;
          res_next.new_stack_ptr = sp_in;
          res_next.if_out        = if_v;
          res_next.fault_code    = idt_pkg::FAULT_ABSENT;
          res_next.last          = 1'b1;
          res_valid_next         = 1'b1;
          state_next             = idt_pkg::S_IDLE;
        end else begin
          handler_next  = {gate[63:48], gate[15:0]};
          sel_next      = gate[31:16];
          gate_int_next = (gate_attr[3:0] == idt_pkg::GATE_TYPE_INT);
          sp_work_next  = sp_in;
          step_next     = 2'd0;
          state_next    = idt_pkg::S_PUSH;
        end
      end

      idt_pkg::S_PUSH: begin
        // one push a cycle, writes at or above ram size are skipped
        res_next.kind          = idt_pkg::KIND_STACK;
        res_next.mem_addr      = sp_dec;
        res_next.mem_data      = push_word;
        res_next.handler_addr  = '0;
        res_next.new_stack_ptr = '0;
        res_next.if_out        = 1'b0;
        res_next.fault_code    = idt_pkg::FAULT_NONE;
        res_next.last          = 1'b0;
        res_valid_next         = (sp_dec < ram_limit);
        sp_work_next           = sp_dec;
        if (step == last_step) begin
          state_next = idt_pkg::S_FINAL;
        end else begin
          step_next = step + 2'd1;
        end
      end

      idt_pkg::S_FINAL: begin
        res_next.kind          = idt_pkg::KIND_DELIVER;
        res_next.mem_addr      = '0;
        res_next.mem_data      = '0;
        res_next.handler_addr  = handler;
        res_next.new_stack_ptr = sp_work;
        res_next.if_out        = gate_int ? 1'b0 : if_v;
        res_next.fault_code    = idt_pkg::FAULT_NONE;
        res_next.last          = 1'b1;
        res_valid_next         = 1'b1;
        state_next             = idt_pkg::S_IDLE;
      end

      default: begin
        state_next = idt_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= idt_pkg::S_IDLE;
      pending      <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      pending      <= pending_next;
      result_valid <= res_valid_next;
    end
  end

  // transaction capture and working registers, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      act      <= idt_pkg::action_t'(action);
      vec_in   <= vector;
      ret      <= return_addr;
      // error code only pushed for explicit deliver transactions
      err_on   <= with_error && (idt_pkg::action_t'(action) == idt_pkg::ACT_DELIVER);
      err_word <= error_word;
      sp_in    <= stack_ptr;
      flags    <= flags_in;
      if_v     <= if_in;
    end
    sp_work  <= sp_work_next;
    step     <= step_next;
    handler  <= handler_next;
    sel      <= sel_next;
    gate_int <= gate_int_next;
    res      <= res_next;
  end

  assign kind          = res.kind;
  assign mem_addr      = res.mem_addr;
  assign mem_data      = res.mem_data;
  assign handler_addr  = res.handler_addr;
  assign new_stack_ptr = res.new_stack_ptr;
  assign if_out        = res.if_out;
  assign fault_code    = res.fault_code;
  assign last          = res.last;

  // a frame word is never shown while the sequencer has already returned to idle
  a_push_while_busy: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last) |-> busy)
    else $error("intermediate result shown while idle");

  // stack writes stay inside guest ram
  a_push_in_ram: assert property (@(posedge clk) disable iff (rst)
    (result_valid && kind == idt_pkg::KIND_STACK) |-> (mem_addr < ram_limit))
    else $error("stack write at or above ram size");

  // the cycle after an idle cycle carries at most an acknowledgement
  a_no_push_after_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |=> !(result_valid && kind == idt_pkg::KIND_STACK))
    else $error("stack write directly after idle");

  // the check cycle can only clear pending lines, never set them
  a_check_clears_only: assert property (@(posedge clk) disable iff (rst)
    (state == idt_pkg::S_CHECK) |=> ((pending & ~$past(pending)) == '0))
    else $error("pending line set during delivery");

endmodule

`default_nettype wire
